// ===== rtl/pws_pkg.sv =====
`default_nettype none
package pws_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned OutW = 20;
  localparam int unsigned DimW = 14;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned ClipW = 49;
  localparam int unsigned KW = 17;
  localparam int unsigned NumW = ClipW + KW;
  localparam int unsigned DivSteps = 6;
  localparam int unsigned DivBitsPerStage = 4;
  localparam int unsigned QuoBits = DivSteps * DivBitsPerStage;
  localparam int unsigned SumW = QuoBits + 3;
  localparam logic signed [ClipW-1:0] VisThreshold = ClipW'(656);
  localparam logic signed [OutW-1:0] OutMax = 20'sd524287;
  localparam logic signed [OutW-1:0] OutMin = -20'sd524288;
  localparam logic signed [SumW-1:0] SatMag = SumW'(1 << QuoBits);
  localparam logic [DimW-1:0] WidthReset = 14'd1920;
  localparam logic [DimW-1:0] HeightReset = 14'd1080;

  typedef enum logic [CfgIdxW-1:0] {
    RegCol0A = 3'd0,
    RegCol0B = 3'd1,
    RegCol1A = 3'd2,
    RegCol1B = 3'd3,
    RegCol3A = 3'd4,
    RegCol3B = 3'd5,
    RegWidth = 3'd6,
    RegHeight = 3'd7
  } cfg_reg_e;

  function automatic logic signed [ClipW-1:0] prod_floor(
    input logic signed [CoordW-1:0] a,
    input logic signed [CoordW-1:0] b
  );
    logic signed [2*CoordW-1:0] p;
    begin
      p = a * b;
      prod_floor = ClipW'(p >>> 16);
    end
  endfunction

  function automatic logic signed [OutW-1:0] sat_out(input logic signed [SumW-1:0] v);
    begin
      if (v > SumW'(OutMax)) sat_out = OutMax;
      else if (v < SumW'(OutMin)) sat_out = OutMin;
      else sat_out = OutW'(v);
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/perspective_world_to_screen_core.sv =====
`default_nettype none
// World-to-screen perspective projection.
// Input channel in_valid_i/in_ready_o carries a world point (Q16.16 x, y, z).
// Output channel out_valid_o/out_ready_i returns visible, screen_x, screen_y
// (Q16.4 pixels, saturated; zero when w < 0.01).
// Config channel cfg_valid_i/cfg_ready_o writes register cfg_index_i with
// cfg_data_i: matrix columns 0, 1, 3 (two Q16.16 words each) and the viewport
// size. Write only while the pipeline is empty.
// Throughput: one point per cycle unless the output stalls. Stages: multiply,
// sum, scale multiply, six divider stages of 4 quotient bits each, fixup, output.
// A quotient too large for the divider saturates the output.
// The pipeline advances as a whole when the last stage is empty or taken;
// a stalled receiver freezes every stage, nothing is dropped or repeated.
// Reset clears all valid bits, zeroes the matrix and sets 1920x1080.
module perspective_world_to_screen_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [pws_pkg::CoordW-1:0]   point_x_i,
  input  wire logic signed [pws_pkg::CoordW-1:0]   point_y_i,
  input  wire logic signed [pws_pkg::CoordW-1:0]   point_z_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     visible_o,
  output logic signed [pws_pkg::OutW-1:0]          screen_x_o,
  output logic signed [pws_pkg::OutW-1:0]          screen_y_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [pws_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [pws_pkg::CfgDataW-1:0]        cfg_data_i
);
  import pws_pkg::*;
  localparam int unsigned Lat = DivSteps + 5;

  logic [CfgDataW-1:0] mat_q [6];
  logic [DimW-1:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) mat_q[i] <= '0;
      width_q <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegWidth: width_q <= cfg_data_i[DimW-1:0];
        RegHeight: height_q <= cfg_data_i[DimW-1:0];
        default: mat_q[cfg_index_i] <= cfg_data_i;
      endcase
    end
  end

  logic adv;
  logic [Lat-1:0] v_q;
  assign adv = !v_q[Lat-1] || out_ready_i;
  assign in_ready_o = adv;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[Lat-2:0], in_valid_i};
  end

  // stage 1: products
  logic signed [ClipW-1:0] p_q [3][4];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p_q[c][0] <= prod_floor(mat_q[2*c][31:0], point_x_i);
        p_q[c][1] <= prod_floor(mat_q[2*c][63:32], point_y_i);
        p_q[c][2] <= prod_floor(mat_q[2*c+1][31:0], point_z_i);
        p_q[c][3] <= ClipW'($signed(mat_q[2*c+1][63:32]));
      end
    end
  end

  // stage 2: sums
  logic signed [ClipW-1:0] cx_q, cy_q, w_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q <= p_q[0][0] + p_q[0][1] + p_q[0][2] + p_q[0][3];
      cy_q <= p_q[1][0] + p_q[1][1] + p_q[1][2] + p_q[1][3];
      w_q <= p_q[2][0] + p_q[2][1] + p_q[2][2] + p_q[2][3];
    end
  end

  // stage 3: |n|*k, sign, visibility
  logic [NumW-1:0] nx_q, ny_q;
  logic negx_q, negy_q, vis3_q;
  logic [ClipW-1:0] w3_q;
  logic [KW-1:0] kx3_q, ky3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [ClipW-1:0] mx, my;
      logic signed [ClipW-1:0] ncy;
      ncy = -cy_q;
      mx = cx_q[ClipW-1] ? ClipW'(-cx_q) : ClipW'(cx_q);
      my = ncy[ClipW-1] ? ClipW'(-ncy) : ClipW'(ncy);
      negx_q <= cx_q[ClipW-1];
      negy_q <= ncy[ClipW-1];
      nx_q <= NumW'(mx) * NumW'({width_q, 3'b0});
      ny_q <= NumW'(my) * NumW'({height_q, 3'b0});
      kx3_q <= {width_q, 3'b0};
      ky3_q <= {height_q, 3'b0};
      vis3_q <= (w_q >= VisThreshold);
      w3_q <= (w_q >= VisThreshold) ? ClipW'(w_q) : ClipW'(1);
    end
  end

  logic [QuoBits-1:0] qx, qy;
  logic ox, oy;
  logic rx, ry;
  pws_div u_divx (.clk_i, .en_i(adv), .num_i(nx_q), .den_i(w3_q),
                  .quo_o(qx), .ovf_o(ox), .rem_nz_o(rx));
  pws_div u_divy (.clk_i, .en_i(adv), .num_i(ny_q), .den_i(w3_q),
                  .quo_o(qy), .ovf_o(oy), .rem_nz_o(ry));

  logic negx_p [DivSteps], negy_p [DivSteps], vis_p [DivSteps];
  logic [KW-1:0] kx_p [DivSteps], ky_p [DivSteps];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      negx_p[0] <= negx_q; negy_p[0] <= negy_q; vis_p[0] <= vis3_q;
      kx_p[0] <= kx3_q; ky_p[0] <= ky3_q;
      for (int s = 1; s < DivSteps; s++) begin
        negx_p[s] <= negx_p[s-1]; negy_p[s] <= negy_p[s-1];
        vis_p[s] <= vis_p[s-1]; kx_p[s] <= kx_p[s-1]; ky_p[s] <= ky_p[s-1];
      end
    end
  end

  // fixup + saturate
  logic signed [SumW-1:0] tx_q, ty_q;
  logic vis8_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic signed [SumW-1:0] sx, sy;
      sx = ox ? SatMag : $signed({3'b0, qx});
      sy = oy ? SatMag : $signed({3'b0, qy});
      if (negx_p[DivSteps-1]) sx = -(sx + SumW'(rx));
      if (negy_p[DivSteps-1]) sy = -(sy + SumW'(ry));
      tx_q <= sx + $signed(SumW'(kx_p[DivSteps-1])) + SumW'(8);
      ty_q <= sy + $signed(SumW'(ky_p[DivSteps-1])) - SumW'(8);
      vis8_q <= vis_p[DivSteps-1];
    end
  end

  logic vis_q;
  logic signed [OutW-1:0] sx_q, sy_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vis_q <= vis8_q;
      sx_q <= vis8_q ? sat_out(tx_q) : '0;
      sy_q <= vis8_q ? sat_out(ty_q) : '0;
    end
  end

  assign out_valid_o = v_q[Lat-1];
  assign visible_o = vis_q;
  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(screen_x_o))
    else $error("output changed during stall");
  a_invis_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> screen_x_o == '0 && screen_y_o == '0)
    else $error("invisible point not zero");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipeline stalled while empty at output");
endmodule
`default_nettype wire

// ===== rtl/pws_div.sv =====
`default_nettype none
module pws_div (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [pws_pkg::NumW-1:0]      num_i,
  input  wire logic [pws_pkg::ClipW-1:0]     den_i,
  output logic [pws_pkg::QuoBits-1:0]        quo_o,
  output logic                               ovf_o,
  output logic                               rem_nz_o
);
  import pws_pkg::*;
  localparam int unsigned RemW = ClipW + 1;
  localparam int unsigned HiW = NumW - QuoBits;

  for (genvar s = 0; s < DivSteps; s++) begin : g_st
    logic [QuoBits-1:0] n_in, n_d, n_q;
    logic [ClipW-1:0] r_in, r_d, r_q;
    logic [ClipW-1:0] d_in, d_q;
    logic o_in, o_q;
    if (s == 0) begin : g_head
      logic [ClipW-1:0] hi;
      assign hi = {{(ClipW-HiW){1'b0}}, num_i[NumW-1:QuoBits]};
      assign n_in = num_i[QuoBits-1:0];
      assign r_in = hi;
      assign d_in = den_i;
      assign o_in = (hi >= den_i);
    end else begin : g_body
      assign n_in = g_st[s-1].n_q;
      assign r_in = g_st[s-1].r_q;
      assign d_in = g_st[s-1].d_q;
      assign o_in = g_st[s-1].o_q;
    end
    always_comb begin
      logic [RemW-1:0] t;
      t = '0;
      n_d = n_in;
      r_d = r_in;
      for (int b = 0; b < DivBitsPerStage; b++) begin
        t = {r_d, n_d[QuoBits-1]};
        n_d = {n_d[QuoBits-2:0], 1'b0};
        if (t >= {1'b0, d_in}) begin
          t = t - {1'b0, d_in};
          n_d[0] = 1'b1;
        end
        r_d = t[ClipW-1:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q <= n_d;
        r_q <= r_d;
        d_q <= d_in;
        o_q <= o_in;
      end
    end
  end

  assign quo_o = g_st[DivSteps-1].n_q;
  assign ovf_o = g_st[DivSteps-1].o_q;
  assign rem_nz_o = (g_st[DivSteps-1].r_q != '0);
endmodule
`default_nettype wire
